[design/tlqs_pkg.sv]
// ----------------------------------------------------------------------------
// tlqs_pkg
// Shared types and constants for the three-level queue scheduler.
// ----------------------------------------------------------------------------
package tlqs_pkg;

    localparam int MAX_TASKS = 64;
    localparam int TW        = $clog2(MAX_TASKS);
    localparam int LW        = TW + 1;
    localparam int NQUEUES   = 3;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_YIELD = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    localparam logic [LW-1:0] EMPTY_MARK = LW'(MAX_TASKS);

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] task_id;
        logic [1:0] queue_index;
        logic [7:0] priority_req;
        logic       runnable;
    } tlqs_in_t;

    typedef struct packed {
        logic [5:0] run_task;
        logic       run_valid;
        logic [1:0] status;
    } tlqs_out_t;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,      // capture the request
        OP_ADD_PRI,    // write priority of the request task
        OP_APP_CUR,    // choose current task for append/unlink
        OP_APP_REQ,    // choose request task for append
        OP_UNLINK,     // unlink the selected task
        OP_APPEND,     // append the selected task
        OP_SCAN_INIT,  // load walk pointer from head of scan queue
        OP_SCAN_STEP,  // advance walk pointer
        OP_SCAN_NEXTQ, // rotate scan queue
        OP_FOUND,      // commit chosen task
        OP_KEEP,       // current task keeps running
        OP_NONE_FOUND, // nothing runnable
        OP_SET_RUN,    // write runnable flag
        OP_REJECT      // add of a task that is already queued
    } tlqs_op_t;

    typedef struct packed {
        tlqs_op_t op;
    } tlqs_cmd_t;

    typedef struct packed {
        logic keep;        // current task keeps running
        logic cur_expired; // current task must be requeued
        logic cur_queued;
        logic req_queued;
        logic walk_end;    // walk pointer hit end or step limit
        logic walk_hit;    // walk pointer on a runnable task with nonzero priority
    } tlqs_stat_t;

    function automatic logic [1:0] tt_lookup(input logic [1:0] q, input logic odd);
        logic [1:0] r;
        r = 2'd0;
        unique case (q)
            2'd0:    r = odd ? 2'd1 : 2'd2;
            2'd1:    r = odd ? 2'd2 : 2'd0;
            default: r = odd ? 2'd0 : 2'd1;
        endcase
        return r;
    endfunction

endpackage

[design/tlqs_datapath.sv]
// ----------------------------------------------------------------------------
// tlqs_datapath
// Task tables, queue links and scan pointer of the scheduler.
// ----------------------------------------------------------------------------
module tlqs_datapath
    import tlqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tlqs_in_t   req,
    input  tlqs_cmd_t  cmd,
    output tlqs_stat_t stat,
    output tlqs_out_t  res
);

    tlqs_in_t           req_reg;
    logic [LW-1:0]      next_link [MAX_TASKS];
    logic [LW-1:0]      prev_link [MAX_TASKS];
    logic [1:0]         home_q    [MAX_TASKS];
    logic [7:0]         pri_mem   [MAX_TASKS];
    logic [MAX_TASKS-1:0] queued_reg, runnable_reg;
    logic [LW-1:0]      head_reg [NQUEUES];
    logic [LW-1:0]      tail_reg [NQUEUES];
    logic [9:0]         slices_reg;
    logic [1:0]         scan_q_reg;
    logic [TW-1:0]      cur_reg;
    logic [7:0]         cur_pri_reg;
    logic               has_cur_reg;
    logic [TW-1:0]      sel_reg;
    logic [1:0]         app_q_reg;
    logic [LW-1:0]      walk_reg;
    logic [LW-1:0]      steps_reg;
    tlqs_out_t          res_reg;

    // Registered read data of the link and priority tables.
    logic [LW-1:0]      nl_rd_reg;
    logic [7:0]         pri_rd_reg;
    logic [LW-1:0]      p_rd_reg;
    logic [LW-1:0]      n_rd_reg;
    logic [1:0]         hq_rd_reg;

    logic [TW-1:0] wt;
    logic [1:0]    qsel, hq, dst;
    logic [LW-1:0] tl;
    logic [9:0]    prod;

    assign wt   = walk_reg[TW-1:0];
    assign qsel = (req_reg.queue_index == 2'd3) ? 2'd2 : req_reg.queue_index;
    assign hq   = (hq_rd_reg == 2'd3) ? 2'd2 : hq_rd_reg;
    assign dst  = (cmd.op == OP_APP_REQ) ? qsel : tt_lookup(scan_q_reg, cur_pri_reg[0]);

    always_comb
    begin
        unique case (scan_q_reg)
            2'd0:    prod = 10'(pri_rd_reg);
            2'd1:    prod = {1'b0, pri_rd_reg, 1'b0};
            default: prod = {pri_rd_reg, 2'b00};
        endcase
    end

    assign tl = tail_reg[app_q_reg];

    assign stat.keep        = has_cur_reg && (slices_reg != 10'd0) && runnable_reg[cur_reg];
    assign stat.cur_expired = has_cur_reg && (slices_reg == 10'd0);
    assign stat.cur_queued  = queued_reg[cur_reg];
    assign stat.req_queued  = queued_reg[req_reg.task_id];
    assign stat.walk_end    = (walk_reg == EMPTY_MARK) || (steps_reg == LW'(MAX_TASKS));
    assign stat.walk_hit    = runnable_reg[wt] && (pri_rd_reg != 8'd0);
    assign res = res_reg;

    // Table storage: one read address per table per cycle, data registered.
    // The walk reads the entry that the walk pointer moves to next.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ADD_PRI: pri_mem[req_reg.task_id] <= req_reg.priority_req;
            OP_APP_CUR:
            begin
                p_rd_reg  <= prev_link[cur_reg];
                n_rd_reg  <= next_link[cur_reg];
                hq_rd_reg <= home_q[cur_reg];
            end
            OP_UNLINK:
            begin
                if (p_rd_reg != EMPTY_MARK) next_link[p_rd_reg[TW-1:0]] <= n_rd_reg;
                if (n_rd_reg != EMPTY_MARK) prev_link[n_rd_reg[TW-1:0]] <= p_rd_reg;
            end
            OP_APPEND:
            begin
                next_link[sel_reg] <= EMPTY_MARK;
                prev_link[sel_reg] <= tl;
                if (tl != EMPTY_MARK) next_link[tl[TW-1:0]] <= {1'b0, sel_reg};
                home_q[sel_reg] <= app_q_reg;
            end
            OP_SCAN_INIT:
            begin
                nl_rd_reg  <= next_link[head_reg[scan_q_reg][TW-1:0]];
                pri_rd_reg <= pri_mem[head_reg[scan_q_reg][TW-1:0]];
            end
            OP_SCAN_STEP:
            begin
                nl_rd_reg  <= next_link[nl_rd_reg[TW-1:0]];
                pri_rd_reg <= pri_mem[nl_rd_reg[TW-1:0]];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg      <= '0;
            queued_reg   <= '0;
            runnable_reg <= '0;
            for (int i = 0; i < NQUEUES; i++)
            begin
                head_reg[i] <= EMPTY_MARK;
                tail_reg[i] <= EMPTY_MARK;
            end
            slices_reg  <= '0;
            scan_q_reg  <= '0;
            cur_reg     <= '0;
            cur_pri_reg <= '0;
            has_cur_reg <= 1'b0;
            sel_reg     <= '0;
            app_q_reg   <= '0;
            walk_reg    <= EMPTY_MARK;
            steps_reg   <= '0;
            res_reg     <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LATCH:
                begin
                    req_reg <= req;
                    res_reg <= '0;
                end
                OP_SET_RUN: runnable_reg[req_reg.task_id] <= req_reg.runnable;
                OP_APP_CUR:
                begin
                    sel_reg   <= cur_reg;
                    app_q_reg <= dst;
                end
                OP_APP_REQ:
                begin
                    sel_reg   <= req_reg.task_id;
                    app_q_reg <= dst;
                end
                OP_UNLINK:
                begin
                    if (p_rd_reg == EMPTY_MARK) head_reg[hq] <= n_rd_reg;
                    if (n_rd_reg == EMPTY_MARK) tail_reg[hq] <= p_rd_reg;
                    queued_reg[sel_reg] <= 1'b0;
                end
                OP_APPEND:
                begin
                    if (tl == EMPTY_MARK) head_reg[app_q_reg] <= {1'b0, sel_reg};
                    tail_reg[app_q_reg] <= {1'b0, sel_reg};
                    queued_reg[sel_reg] <= 1'b1;
                    if (req_reg.req_type == REQ_ADD) res_reg.status <= ST_OK;
                end
                OP_SCAN_INIT:
                begin
                    walk_reg  <= head_reg[scan_q_reg];
                    steps_reg <= '0;
                end
                OP_SCAN_STEP:
                begin
                    walk_reg  <= nl_rd_reg;
                    steps_reg <= steps_reg + 1'b1;
                end
                OP_SCAN_NEXTQ:
                begin
                    scan_q_reg <= (scan_q_reg == 2'd2) ? 2'd0 : scan_q_reg + 2'd1;
                end
                OP_FOUND:
                begin
                    slices_reg  <= prod - 10'd1;
                    cur_reg     <= wt;
                    cur_pri_reg <= pri_rd_reg;
                    has_cur_reg <= 1'b1;
                    res_reg     <= '{run_task: wt, run_valid: 1'b1, status: ST_OK};
                end
                OP_KEEP:
                begin
                    slices_reg <= slices_reg - 10'd1;
                    res_reg    <= '{run_task: cur_reg, run_valid: 1'b1, status: ST_OK};
                end
                OP_NONE_FOUND:
                begin
                    has_cur_reg <= 1'b0;
                    res_reg     <= '{run_task: '0, run_valid: 1'b0, status: ST_NONE};
                end
                OP_REJECT: res_reg.status <= ST_REJECT;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_keep_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_KEEP |=> slices_reg == $past(slices_reg) - 10'd1)
        else $error("slice count not decremented");
    a_found_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FOUND |=> res_reg.run_valid && has_cur_reg)
        else $error("chosen task not marked");
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_NONE_FOUND |=> !has_cur_reg && res_reg.status == ST_NONE)
        else $error("empty scan not reported");
`endif

endmodule

[design/tlqs_ctrl.sv]
// ----------------------------------------------------------------------------
// tlqs_ctrl
// Sequencer for add, set-runnable and yield transactions.
// ----------------------------------------------------------------------------
module tlqs_ctrl
    import tlqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  tlqs_in_t   req,
    input  tlqs_stat_t stat,
    output tlqs_cmd_t  cmd,
    output logic       out_valid,
    input  logic       out_stall
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ADD_SEL, S_APPEND, S_Y_UNLINK, S_Y_APPEND,
        S_SCAN_INIT, S_SCAN, S_NEXTQ, S_OUT
    } state_t;

    state_t     state_reg;
    logic       out_valid_reg;
    logic [1:0] qcnt_reg;
    // The datapath holds the latched request; the controller keeps its type.
    logic [1:0] req_type_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:     if (in_valid) cmd.op = OP_LATCH;
            S_DECODE:
            begin
                unique case (req_type_reg)
                    REQ_ADD:   cmd.op = stat.req_queued ? OP_REJECT : OP_ADD_PRI;
                    REQ_SET:   cmd.op = OP_SET_RUN;
                    REQ_YIELD: cmd.op = stat.keep ? OP_KEEP :
                                        (stat.cur_expired ? OP_APP_CUR : OP_SCAN_INIT);
                    default:   cmd.op = OP_NONE;
                endcase
            end
            S_ADD_SEL:  cmd.op = OP_APP_REQ;
            S_APPEND:   cmd.op = OP_APPEND;
            S_Y_UNLINK: cmd.op = stat.cur_queued ? OP_UNLINK : OP_NONE;
            S_Y_APPEND: cmd.op = OP_APPEND;
            S_SCAN_INIT: cmd.op = OP_SCAN_INIT;
            S_SCAN:
            begin
                if (stat.walk_end)      cmd.op = (qcnt_reg == 2'd2) ? OP_NONE_FOUND : OP_SCAN_NEXTQ;
                else if (stat.walk_hit) cmd.op = OP_FOUND;
                else                    cmd.op = OP_SCAN_STEP;
            end
            S_NEXTQ:    cmd.op = OP_SCAN_INIT;
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            qcnt_reg      <= '0;
            req_type_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_type_reg <= req.req_type;
                        state_reg    <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    qcnt_reg <= '0;
                    priority case (1'b1)
                        req_type_reg == REQ_ADD && !stat.req_queued: state_reg <= S_ADD_SEL;
                        req_type_reg == REQ_YIELD && !stat.keep && stat.cur_expired:
                            state_reg <= S_Y_UNLINK;
                        req_type_reg == REQ_YIELD && !stat.keep: state_reg <= S_SCAN;
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_ADD_SEL:  state_reg <= S_APPEND;
                S_APPEND:   state_reg <= S_OUT;
                S_Y_UNLINK: state_reg <= S_Y_APPEND;
                S_Y_APPEND: state_reg <= S_SCAN_INIT;
                S_SCAN_INIT: state_reg <= S_SCAN;
                S_SCAN:
                begin
                    if (stat.walk_end)
                    begin
                        if (qcnt_reg == 2'd2) state_reg <= S_OUT;
                        else
                        begin
                            qcnt_reg  <= qcnt_reg + 2'd1;
                            state_reg <= S_NEXTQ;
                        end
                    end
                    else if (stat.walk_hit) state_reg <= S_OUT;
                end
                S_NEXTQ:    state_reg <= S_SCAN;
                S_OUT:
                begin
                    if (!out_valid_reg) out_valid_reg <= 1'b1;
                    else if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_out_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == S_OUT)
        else $error("result shown outside output state");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NEXTQ |-> qcnt_reg != 2'd0)
        else $error("queue rotation count wrong");
`endif

endmodule

[design/three_level_queue_scheduler_top.sv]
// ----------------------------------------------------------------------------
// three_level_queue_scheduler_top
// Three-queue feedback scheduler with linked task queues.
// ----------------------------------------------------------------------------
//  channel | signals                        | payload
//  input   | in_valid, in_stall             | in_data  (tlqs_in_t)
//  output  | out_valid, out_stall           | out_data (tlqs_out_t)
//
// One transaction is taken at a time. A set, a kept yield and a rejected add
// go from decode straight to the output state; an add first selects and
// appends the task. A yield that does not keep the current task requeues it if
// its slices have run out, then walks the queues, reading one link per cycle.
// The next input can be taken in the cycle after the result is accepted. Reset
// clears queues, flags and the current task with no clearing pass. The result
// is held until out_stall is low; the input stays stalled until then.
// ----------------------------------------------------------------------------
module three_level_queue_scheduler_top
    import tlqs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  tlqs_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output tlqs_out_t out_data
);

    tlqs_cmd_t  cmd;
    tlqs_stat_t stat;

    // The controller keeps the request type; the datapath keeps the request.
    tlqs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req(in_data), .stat(stat), .cmd(cmd),
        .out_valid(out_valid), .out_stall(out_stall)
    );

    tlqs_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .req(in_data), .cmd(cmd),
        .stat(stat), .res(out_data)
    );

endmodule
